>>> design/sparse_pointer_table_unpacker_defines.svh
// assertion macros used by the port-level checker file
`ifndef SPARSE_POINTER_TABLE_UNPACKER_DEFINES_SVH
`define SPARSE_POINTER_TABLE_UNPACKER_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define SPU_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("spu check failed: same-cycle rule");

// consequent must hold in the cycle after the antecedent
`define SPU_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("spu check failed: next-cycle rule");

`endif

>>> design/spu_pkg.sv
// shared constants, codes and types of the sparse pointer table unpacker
`default_nettype none

package spu_pkg;

  // table geometry
  localparam int TABLE_ENTRIES = 1024;
  localparam int ADDR_W        = $clog2(TABLE_ENTRIES);
  localparam int POS_W         = $clog2(TABLE_ENTRIES + 1);

  // field widths
  localparam int OP_W     = 2;
  localparam int PACK_W   = 4;
  localparam int WORD_W   = 16;
  localparam int INDEX_W  = 10;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 11;
  localparam int RD_CMP_W = (POS_W > INDEX_W) ? POS_W : INDEX_W;

  // command queue
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // data constants
  localparam logic [WORD_W-1:0] EMPTY_SLOT = 16'hffff;
  localparam logic [WORD_W-1:0] TOP_BIT    = 16'h8000;

  // op codes
  localparam logic [OP_W-1:0] OP_START = 2'd0;
  localparam logic [OP_W-1:0] OP_WORD  = 2'd1;
  localparam logic [OP_W-1:0] OP_READ  = 2'd2;
  localparam logic [OP_W-1:0] OP_NOP   = 2'd3;

  // pack types
  localparam logic [PACK_W-1:0] PT_EMPTY = 4'd0;
  localparam logic [PACK_W-1:0] PT_RAW   = 4'd1;
  localparam logic [PACK_W-1:0] PT_MASK  = 4'd2;

  // classified command kinds
  typedef logic [2:0] kind_t;
  localparam kind_t CMD_START_EMPTY = 3'd0;
  localparam kind_t CMD_START_RAW   = 3'd1;
  localparam kind_t CMD_START_MASK  = 3'd2;
  localparam kind_t CMD_START_BAD   = 3'd3;
  localparam kind_t CMD_WORD        = 3'd4;
  localparam kind_t CMD_READ        = 3'd5;
  localparam kind_t CMD_NOP         = 3'd6;

  // region modes
  typedef logic [1:0] mode_t;
  localparam mode_t MODE_IDLE = 2'd0;
  localparam mode_t MODE_RAW  = 2'd1;
  localparam mode_t MODE_MASK = 2'd2;
  localparam mode_t MODE_DONE = 2'd3;

  // result status
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_TYPE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_IGNORED  = 2'd2;

  // one queued command
  typedef struct packed {
    kind_t               kind;
    logic [WORD_W-1:0]   data_word;
    logic [INDEX_W-1:0]  read_index;
  } cmd_t;

endpackage

`default_nettype wire

>>> design/sparse_pointer_table_unpacker.sv
// Sparse pointer table unpacker: fills a pointer table from a packed word stream.
//
// Input beats carry op, pack_type, data_word and read_index under in_valid/in_ready.
// Each input beat yields exactly one result beat (status, read_value,
// entries_counted, region_complete) under out_valid/out_ready, in order.
// The configuration channel (cfg_valid/cfg_ready/cfg_data) sets the pointer
// offset; it is always ready and should be written only while the block is idle.
// A front part classifies beats into a four-deep command queue; a back part runs
// them against a single-port-write table memory, one table write per cycle.
// In the back part, reads go through a registered memory read, and bitmask words
// write one empty slot per clear mask bit expanded. An empty-type start adds a
// clear sweep of the table before the next beat is run. Results are registered.
// After reset the table is swept to empty slots with in_ready low.
// When the receiver stalls the result register holds; beats keep being taken
// into the four-deep queue until it fills.
`default_nettype none

module sparse_pointer_table_unpacker (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [spu_pkg::WORD_W-1:0]    cfg_data,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [spu_pkg::OP_W-1:0]      op,
  input  wire logic [spu_pkg::PACK_W-1:0]    pack_type,
  input  wire logic [spu_pkg::WORD_W-1:0]    data_word,
  input  wire logic [spu_pkg::INDEX_W-1:0]   read_index,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [spu_pkg::STATUS_W-1:0]       status,
  output logic [spu_pkg::WORD_W-1:0]         read_value,
  output logic [spu_pkg::COUNT_W-1:0]        entries_counted,
  output logic                               region_complete
);

  import spu_pkg::*;

  logic  init_busy;
  logic  q_not_full;
  logic  q_push;
  cmd_t  q_cmd;
  logic  cmd_valid;
  cmd_t  cmd;
  logic  cmd_pop;

  // offset register is always ready, so it can take a write every cycle
  assign cfg_ready = 1'b1;

  // front: accept and classify
  spu_front u_front (
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .op         (op),
    .pack_type  (pack_type),
    .data_word  (data_word),
    .read_index (read_index),
    .init_busy  (init_busy),
    .q_not_full (q_not_full),
    .q_push     (q_push),
    .q_cmd      (q_cmd)
  );

  // command queue
  spu_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_cmd   (q_cmd),
    .not_full   (q_not_full),
    .pop        (cmd_pop),
    .head_valid (cmd_valid),
    .head_cmd   (cmd)
  );

  // back: execute against the table
  spu_back u_back (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_valid),
    .cfg_data        (cfg_data),
    .cmd_valid       (cmd_valid),
    .cmd             (cmd),
    .cmd_pop         (cmd_pop),
    .init_busy       (init_busy),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .status          (status),
    .read_value      (read_value),
    .entries_counted (entries_counted),
    .region_complete (region_complete)
  );

endmodule

`default_nettype wire

>>> design/spu_ram.sv
// generic single-write, single-read ram with registered read data
`default_nettype none

module spu_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port, data holds between reads
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

>>> design/spu_queue.sv
// short command queue between the front and back parts
`default_nettype none

module spu_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  spu_pkg::cmd_t      push_cmd,
  output logic               not_full,
  input  wire logic          pop,
  output logic               head_valid,
  output spu_pkg::cmd_t      head_cmd
);

  import spu_pkg::*;

  cmd_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign not_full   = (count != QCNT_W'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_cmd   = slots[rd_ptr];
  assign do_push    = push && not_full;
  assign do_pop     = pop && head_valid;

  // slot storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

>>> design/spu_front.sv
// front part: input handshake and command classification
`default_nettype none

module spu_front (
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [spu_pkg::OP_W-1:0]     op,
  input  wire logic [spu_pkg::PACK_W-1:0]   pack_type,
  input  wire logic [spu_pkg::WORD_W-1:0]   data_word,
  input  wire logic [spu_pkg::INDEX_W-1:0]  read_index,
  input  wire logic                         init_busy,
  input  wire logic                         q_not_full,
  output logic                              q_push,
  output spu_pkg::cmd_t                     q_cmd
);

  import spu_pkg::*;

  kind_t kind;

  // no items during the clearing pass after reset
  assign in_ready = q_not_full && !init_busy;
  assign q_push   = in_valid && in_ready;

  // classify op and pack type into a command kind
  always_comb begin
    unique case (op)
      OP_START: begin
        unique case (pack_type)
          PT_EMPTY: kind = CMD_START_EMPTY;
          PT_RAW:   kind = CMD_START_RAW;
          PT_MASK:  kind = CMD_START_MASK;
          default:  kind = CMD_START_BAD;
        endcase
      end
      OP_WORD: kind = CMD_WORD;
      OP_READ: kind = CMD_READ;
      OP_NOP:  kind = CMD_NOP;
      default: kind = CMD_NOP;
    endcase
  end

  assign q_cmd.kind       = kind;
  assign q_cmd.data_word  = data_word;
  assign q_cmd.read_index = read_index;

endmodule

`default_nettype wire

>>> design/spu_back.sv
// back part: region state, table memory, clear sweeps and result register
`default_nettype none

module spu_back (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [spu_pkg::WORD_W-1:0]    cfg_data,
  input  wire logic                          cmd_valid,
  input  spu_pkg::cmd_t                      cmd,
  output logic                               cmd_pop,
  output logic                               init_busy,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [spu_pkg::STATUS_W-1:0]       status,
  output logic [spu_pkg::WORD_W-1:0]         read_value,
  output logic [spu_pkg::COUNT_W-1:0]        entries_counted,
  output logic                               region_complete
);

  import spu_pkg::*;

  localparam logic [1:0] S_CLEAR  = 2'd0;
  localparam logic [1:0] S_RUN    = 2'd1;
  localparam logic [1:0] S_EXPAND = 2'd2;
  localparam logic [1:0] S_READ   = 2'd3;

  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(TABLE_ENTRIES - 1);
  localparam logic [POS_W-1:0]  POS_END   = POS_W'(TABLE_ENTRIES);
  localparam logic [RD_CMP_W-1:0] RD_END  = RD_CMP_W'(TABLE_ENTRIES);

  logic [1:0]        state, state_next;
  logic              init_sweep, init_sweep_next;
  logic [ADDR_W-1:0] clr_addr, clr_addr_next;
  mode_t             mode, mode_next;
  logic [POS_W-1:0]  pos, pos_next;
  logic [WORD_W-1:0] pmask, pmask_next;
  logic [WORD_W-1:0] mbit, mbit_next;
  logic              awaiting, awaiting_next;
  logic              rd_in_range, rd_in_range_next;
  logic [WORD_W-1:0] offset;

  logic              can_emit;
  logic              emit;
  logic [STATUS_W-1:0] emit_status;
  logic [WORD_W-1:0] emit_value;
  logic [POS_W-1:0]  pos_inc;
  logic [WORD_W-1:0] shifted_word;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [WORD_W-1:0] ram_rdata;

  assign init_busy    = init_sweep;
  assign can_emit     = !out_valid || out_ready;
  assign pos_inc      = pos + 1'b1;
  assign shifted_word = cmd.data_word + offset;
  assign ram_raddr    = ADDR_W'(cmd.read_index);

  // pointer table
  spu_ram #(
    .WIDTH (WORD_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_table (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  // sequencer: one table write per cycle at most
  always_comb begin
    state_next       = state;
    init_sweep_next  = init_sweep;
    clr_addr_next    = clr_addr;
    mode_next        = mode;
    pos_next         = pos;
    pmask_next       = pmask;
    mbit_next        = mbit;
    awaiting_next    = awaiting;
    rd_in_range_next = rd_in_range;
    ram_we           = 1'b0;
    ram_waddr        = ADDR_W'(pos);
    ram_wdata        = EMPTY_SLOT;
    ram_re           = 1'b0;
    cmd_pop          = 1'b0;
    emit             = 1'b0;
    emit_status      = ST_OK;
    emit_value       = '0;

    unique case (state)
      // sweep the table to empty slots
      S_CLEAR: begin
        ram_we        = 1'b1;
        ram_waddr     = clr_addr;
        clr_addr_next = clr_addr + 1'b1;
        if (clr_addr == LAST_ADDR) begin
          clr_addr_next   = '0;
          init_sweep_next = 1'b0;
          state_next      = S_RUN;
        end
      end

      // take the next command
      S_RUN: begin
        if (cmd_valid) begin
          case (cmd.kind) inside
            CMD_START_EMPTY, CMD_START_RAW, CMD_START_MASK, CMD_START_BAD: begin
              if (can_emit) begin
                cmd_pop       = 1'b1;
                emit          = 1'b1;
                pos_next      = '0;
                pmask_next    = '0;
                mbit_next     = TOP_BIT;
                awaiting_next = 1'b1;
                case (cmd.kind)
                  CMD_START_EMPTY: begin
                    mode_next  = MODE_DONE;
                    state_next = S_CLEAR;
                  end
                  CMD_START_RAW:  mode_next = MODE_RAW;
                  CMD_START_MASK: mode_next = MODE_MASK;
                  default: begin
                    mode_next   = MODE_IDLE;
                    emit_status = ST_BAD_TYPE;
                  end
                endcase
              end
            end
            CMD_WORD: begin
              if (mode == MODE_RAW) begin
                if (can_emit) begin
                  cmd_pop   = 1'b1;
                  emit      = 1'b1;
                  ram_we    = 1'b1;
                  ram_wdata = (cmd.data_word == EMPTY_SLOT) ? EMPTY_SLOT : shifted_word;
                  pos_next  = pos_inc;
                  if (pos_inc >= POS_END) begin
                    mode_next = MODE_DONE;
                  end
                end
              end else if (mode == MODE_MASK) begin
                cmd_pop    = 1'b1;
                state_next = S_EXPAND;
                if (awaiting) begin
                  pmask_next    = cmd.data_word;
                  awaiting_next = 1'b0;
                  mbit_next     = TOP_BIT;
                end else begin
                  ram_we    = 1'b1;
                  ram_wdata = shifted_word;
                  pos_next  = pos_inc;
                  mbit_next = mbit >> 1;
                  if (pos_inc >= POS_END) begin
                    mode_next = MODE_DONE;
                  end
                end
              end else if (can_emit) begin
                cmd_pop     = 1'b1;
                emit        = 1'b1;
                emit_status = ST_IGNORED;
              end
            end
            CMD_READ: begin
              cmd_pop          = 1'b1;
              ram_re           = 1'b1;
              rd_in_range_next = (RD_CMP_W'(cmd.read_index) < RD_END);
              state_next       = S_READ;
            end
            default: begin
              if (can_emit) begin
                cmd_pop = 1'b1;
                emit    = 1'b1;
              end
            end
          endcase
        end
      end

      // write empty slots for clear mask bits up to the next set bit or the mask's end, then give the result
      S_EXPAND: begin
        if (mode != MODE_MASK || (mbit != '0 && (pmask & mbit) != '0)) begin
          if (can_emit) begin
            emit       = 1'b1;
            state_next = S_RUN;
          end
        end else if (mbit == '0) begin
          if (can_emit) begin
            emit          = 1'b1;
            awaiting_next = 1'b1;
            mbit_next     = TOP_BIT;
            state_next    = S_RUN;
          end
        end else begin
          ram_we    = 1'b1;
          ram_wdata = EMPTY_SLOT;
          pos_next  = pos_inc;
          mbit_next = mbit >> 1;
          if (pos_inc >= POS_END) begin
            mode_next = MODE_DONE;
          end
        end
      end

      // table data arrives in the cycle after the read
      S_READ: begin
        if (can_emit) begin
          emit       = 1'b1;
          emit_value = rd_in_range ? ram_rdata : EMPTY_SLOT;
          state_next = S_RUN;
        end
      end

      default: begin
        state_next = S_RUN;
      end
    endcase
  end

  // control and region state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      init_sweep  <= 1'b1;
      clr_addr    <= '0;
      mode        <= MODE_IDLE;
      pos         <= '0;
      pmask       <= '0;
      mbit        <= TOP_BIT;
      awaiting    <= 1'b1;
      rd_in_range <= 1'b0;
    end else begin
      state       <= state_next;
      init_sweep  <= init_sweep_next;
      clr_addr    <= clr_addr_next;
      mode        <= mode_next;
      pos         <= pos_next;
      pmask       <= pmask_next;
      mbit        <= mbit_next;
      awaiting    <= awaiting_next;
      rd_in_range <= rd_in_range_next;
    end
  end

  // offset register
  always_ff @(posedge clk) begin
    if (rst) begin
      offset <= '0;
    end else if (cfg_we) begin
      offset <= cfg_data;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      status          <= emit_status;
      read_value      <= emit_value;
      entries_counted <= COUNT_W'(pos_next);
      region_complete <= (mode_next == MODE_DONE);
    end
  end

endmodule

`default_nettype wire

>>> design/spu_checker.sv
// port-level checks of the unpacker and their bind
`default_nettype none

`include "sparse_pointer_table_unpacker_defines.svh"

module spu_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          in_ready,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic [spu_pkg::STATUS_W-1:0]  status,
  input wire logic [spu_pkg::WORD_W-1:0]    read_value,
  input wire logic [spu_pkg::COUNT_W-1:0]   entries_counted,
  input wire logic                          region_complete
);

  import spu_pkg::*;

  // stalled result beat holds
  `SPU_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(status) && $stable(read_value) && $stable(entries_counted) && $stable(region_complete))

  // bad pack type leaves an empty, incomplete region
  `SPU_ASSERT_SAME(a_bad_type, clk, rst, out_valid && status == ST_BAD_TYPE, entries_counted == '0 && !region_complete)

  // only read results carry a value
  `SPU_ASSERT_SAME(a_no_value, clk, rst, out_valid && status != ST_OK, read_value == '0)

  // count never passes the table size
  `SPU_ASSERT_SAME(a_count_max, clk, rst, out_valid, entries_counted <= COUNT_W'(TABLE_ENTRIES))

  // clear sweep holds off input and results right after reset
  `SPU_ASSERT_SAME(a_init_sweep, clk, rst, $fell(rst), !in_ready && !out_valid)

endmodule

bind sparse_pointer_table_unpacker spu_checker u_spu_checker (.*);

`default_nettype wire
